// File: sv/sdcl_pkg.sv
// Package for the SD SPI CSD lock sequencer: types, codes and the CRC7 helper.
// No dependencies.
package sdcl_pkg;

    localparam logic [1:0] FUNC_READ   = 2'd0;
    localparam logic [1:0] FUNC_TOGGLE = 2'd1;
    localparam logic [1:0] FUNC_BYTE   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NODET   = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_RWFAIL  = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
    } sdcl_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       exchange;
        logic       select_card;
        logic       done_res;
        logic [1:0] status;
        logic [1:0] card_type;
        logic       locked;
    } sdcl_result_t;

    function automatic logic [6:0] crc7_add(input logic [6:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic [7:0] d;
        c = {1'b0, crc};
        d = b;
        for (int k = 0; k < 8; k++) begin
            c = {c[6:0], 1'b0};
            if (d[7] ^ c[7]) c = c ^ 8'h09;
            d = {d[6:0], 1'b0};
        end
        return c[6:0];
    endfunction

endpackage

// File: sv/sd_spi_csd_lock_sequencer_core.sv
// Top level of the SD SPI-mode CSD lock sequencer.
// Depends on sdcl_pkg, sdcl_front and sdcl_back.
//
// Takes one transaction per cycle while s_tready is high: each start or byte_done
// item yields at most one result (next byte to exchange, or completion with status).
// An accepted transaction is written into the two-entry queue; the back-end sequencer
// updates its state and writes the result into its output register. While a result
// waits on m_tready the sequencer holds and the queue takes up to two more items
// before s_tready drops. func code 3 and bytes while idle give no result.
module sd_spi_csd_lock_sequencer_core
    import sdcl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // rx_byte[7:0]
    input  logic [1:0]  s_tuser,  // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // tx_byte, exchange, select_card, done_res, status,
                                  // card_type, locked
);
    sdcl_item_t   in_item, q_item;
    sdcl_result_t res;
    logic         q_valid, q_ready;

    assign in_item.func    = s_tuser;
    assign in_item.rx_byte = s_tdata;

    sdcl_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    sdcl_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {res.locked, res.card_type, res.status, res.done_res,
                      res.select_card, res.exchange, res.tx_byte};
endmodule

// File: sv/sdcl_front.sv
// Front end: accepts input transactions, drops ignored codes, feeds the queue.
// Depends on sdcl_pkg.
module sdcl_front
    import sdcl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  sdcl_item_t in_item,
    output logic       q_valid,
    input  logic       q_ready,
    output sdcl_item_t q_item
);
    sdcl_item_t buf_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg, wr_reg;
    logic       push, pop, keep;

    assign in_ready = (cnt_reg != 2'd2);
    assign keep     = (in_item.func != FUNC_UNUSED);
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = buf_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            if (push) begin
                buf_reg[wr_reg] <= in_item;
                wr_reg <= ~wr_reg;
            end
            if (pop) rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// File: sv/sdcl_back.sv
// Back end: the sequencer state machine and the CSD store, with an output register.
// Depends on sdcl_pkg.
module sdcl_back
    import sdcl_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_idx,
    input  logic [15:0]  cfg_data,
    input  logic         q_valid,
    output logic         q_ready,
    input  sdcl_item_t   q_item,
    output logic         out_valid,
    input  logic         out_ready,
    output sdcl_result_t out_res
);
    localparam logic [4:0] PH_IDLE = 5'd0, PH_WAKE = 5'd1, PH_C_PRE = 5'd2,
        PH_C_SEL = 5'd3, PH_C_CMD = 5'd4, PH_C_ARG = 5'd5, PH_C_CRC = 5'd6,
        PH_C_RESP = 5'd7, PH_C_TAIL = 5'd8, PH_BURN = 5'd9, PH_FINAL = 5'd10,
        PH_DWAIT = 5'd11, PH_DREAD = 5'd12, PH_DCRC = 5'd13, PH_TOKEN = 5'd14,
        PH_WDATA = 5'd15, PH_WCRC = 5'd16, PH_DUMMY = 5'd17, PH_BUSY = 5'd18;
    localparam logic [2:0] R_CMD0 = 3'd0, R_CMD8 = 3'd1, R_ACMD41 = 3'd2,
        R_CMD58 = 3'd3, R_CMD1 = 3'd4, R_CMD16 = 3'd5, R_CMD9 = 3'd6, R_CMD27 = 3'd7;
    localparam logic [2:0] CFG_WAKE = 3'd0, CFG_IDLE = 3'd1, CFG_RESP = 3'd2,
        CFG_INIT = 3'd3, CFG_DATA = 3'd4, CFG_BUSY = 3'd5;

    logic [7:0]  wake_reg, idle_reg, resp_reg, data_reg;
    logic [15:0] init_reg, busyp_reg;
    logic [7:0]  csd_reg [16];
    logic [15:0] csd_v_reg;
    logic [4:0]  phase_reg, phase_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [4:0]  idx_reg, idx_next;
    logic [15:0] poll_reg, poll_next, try_reg, try_next;
    logic [6:0]  crc_reg, crc_next;
    logic [1:0]  kind_reg, kind_next;
    logic [31:0] arg_reg, arg_next;
    logic        acmd_reg, acmd_next, sel_reg, sel_next;
    logic [2:0]  ret_reg, ret_next;
    logic [7:0]  last_reg, last_next;
    logic        ov_reg;
    sdcl_result_t res_reg;

    logic        go, emit, is_ex, o_sel, wr_en, clr, tog, lock_bit;
    logic [7:0]  o_tx, rx, wr_data;
    logic [1:0]  o_st;
    logic [3:0]  wr_idx;
    logic [15:0] poll_inc, try_inc;
    logic [31:0] arg_eff;
    logic [15:0] e_wake, e_idle, e_resp, e_data, e_init, e_busy;

    function automatic logic [15:0] eff8(input logic [7:0] v);
        return (v == 8'd0) ? 16'd1 : {8'd0, v};
    endfunction

    assign e_wake = eff8(wake_reg);
    assign e_idle = eff8(idle_reg);
    assign e_resp = eff8(resp_reg);
    assign e_data = eff8(data_reg);
    assign e_init = (init_reg == 16'd0) ? 16'd1 : init_reg;
    assign e_busy = (busyp_reg == 16'd0) ? 16'd1 : busyp_reg;

    assign q_ready = !ov_reg || out_ready;
    assign go      = q_valid && q_ready;
    assign rx      = q_item.rx_byte;
    assign poll_inc = poll_reg + 16'd1;
    assign try_inc  = try_reg + 16'd1;
    assign arg_eff  = acmd_reg ? 32'd0 : arg_reg;
    assign lock_bit = csd_v_reg[14] && csd_reg[14][4];

    always_comb begin
        phase_next = phase_reg; cmd_next = cmd_reg; idx_next = idx_reg;
        poll_next = poll_reg; try_next = try_reg; crc_next = crc_reg;
        kind_next = kind_reg; arg_next = arg_reg; acmd_next = acmd_reg;
        sel_next = sel_reg; ret_next = ret_reg; last_next = last_reg;
        emit = 1'b0; is_ex = 1'b0; o_tx = 8'd0; o_sel = 1'b0; o_st = ST_OK;
        wr_en = 1'b0; wr_idx = 4'd0; wr_data = 8'd0; clr = 1'b0; tog = 1'b0;

        // Inline helpers expressed as flags processed at the end.
        begin : seq
            logic do_x, x_sel, do_fin, do_beg, beg_acmd, do_issue, do_ret, do_cc;
            logic [7:0] x_tx, beg_wire, issue_wire, r;
            logic [31:0] beg_arg;
            logic [2:0] beg_ret;
            logic [1:0] fin_st;
            do_x = 1'b0; x_sel = 1'b0; x_tx = 8'hFF; do_fin = 1'b0; fin_st = ST_OK;
            do_beg = 1'b0; beg_acmd = 1'b0; beg_wire = 8'd0; beg_arg = 32'd0;
            beg_ret = R_CMD0; do_issue = 1'b0; issue_wire = 8'd0; do_ret = 1'b0;
            do_cc = 1'b0; r = 8'd0;
            if (go) begin
                if (q_item.func == FUNC_READ) begin
                    kind_next = 2'd0; acmd_next = 1'b0; poll_next = 16'd0;
                    phase_next = PH_WAKE; do_x = 1'b1;
                end else if (q_item.func == FUNC_TOGGLE) begin
                    tog = 1'b1;
                    do_beg = 1'b1; beg_wire = 8'h5B; beg_ret = R_CMD27;
                end else if (phase_reg != PH_IDLE) begin
                    unique case (phase_reg)
                        PH_WAKE: begin
                            poll_next = poll_inc;
                            if (poll_inc < e_wake) do_x = 1'b1;
                            else begin
                                try_next = 16'd0; do_beg = 1'b1; beg_wire = 8'h40;
                                beg_ret = R_CMD0;
                            end
                        end
                        PH_C_PRE: begin phase_next = PH_C_SEL; do_x = 1'b1; x_sel = 1'b1; end
                        PH_C_SEL: begin
                            phase_next = PH_C_CMD; do_x = 1'b1; x_sel = 1'b1; x_tx = cmd_reg;
                        end
                        PH_C_CMD: begin
                            idx_next = 5'd0; phase_next = PH_C_ARG; do_x = 1'b1; x_sel = 1'b1;
                            x_tx = arg_eff[31:24];
                        end
                        PH_C_ARG: begin
                            idx_next = idx_reg + 5'd1; do_x = 1'b1; x_sel = 1'b1;
                            unique case (idx_reg[1:0])
                                2'd0: x_tx = arg_eff[23:16];
                                2'd1: x_tx = arg_eff[15:8];
                                2'd2: x_tx = arg_eff[7:0];
                                default: begin
                                    phase_next = PH_C_CRC;
                                    x_tx = (cmd_reg == 8'h40) ? 8'h95 :
                                           (cmd_reg == 8'h48) ? 8'h87 : 8'h01;
                                end
                            endcase
                        end
                        PH_C_CRC: begin
                            poll_next = 16'd0; phase_next = PH_C_RESP; do_x = 1'b1;
                            x_sel = 1'b1;
                        end
                        PH_C_RESP: begin
                            poll_next = poll_inc;
                            if (!rx[7] || poll_inc >= e_resp) begin
                                last_next = rx;
                                if (cmd_reg == 8'h48 || cmd_reg == 8'h49 ||
                                    cmd_reg == 8'h5B || cmd_reg == 8'h7A) begin
                                    do_cc = 1'b1; r = rx;
                                end else begin
                                    phase_next = PH_C_TAIL; do_x = 1'b1;
                                end
                            end else begin
                                do_x = 1'b1; x_sel = 1'b1;
                            end
                        end
                        PH_C_TAIL: begin do_cc = 1'b1; r = last_reg; end
                        PH_BURN: begin
                            idx_next = idx_reg + 5'd1;
                            if (idx_reg + 5'd1 < 5'd4) begin do_x = 1'b1; x_sel = 1'b1; end
                            else begin
                                try_next = 16'd0; do_beg = 1'b1;
                                if (cmd_reg == 8'h48) begin
                                    beg_wire = 8'h69; beg_arg = 32'h4000_0000;
                                    beg_acmd = 1'b1; beg_ret = R_ACMD41;
                                end else begin
                                    beg_wire = 8'h41; beg_ret = R_CMD1;
                                end
                            end
                        end
                        PH_FINAL: begin
                            clr = 1'b1; do_beg = 1'b1; beg_wire = 8'h49; beg_ret = R_CMD9;
                        end
                        PH_DWAIT: begin
                            poll_next = poll_inc;
                            if (rx == 8'hFE) begin
                                idx_next = 5'd0; phase_next = PH_DREAD; do_x = 1'b1;
                                x_sel = 1'b1;
                            end else if (rx != 8'hFF || poll_inc >= e_data) begin
                                do_fin = 1'b1; fin_st = ST_RWFAIL;
                            end else begin
                                do_x = 1'b1; x_sel = 1'b1;
                            end
                        end
                        PH_DREAD: begin
                            if (!idx_reg[4]) begin
                                wr_en = 1'b1; wr_idx = idx_reg[3:0]; wr_data = rx;
                            end
                            idx_next = idx_reg + 5'd1;
                            if (idx_reg + 5'd1 >= 5'd16) phase_next = PH_DCRC;
                            do_x = 1'b1; x_sel = 1'b1;
                        end
                        PH_DCRC: begin do_fin = 1'b1; fin_st = ST_OK; end
                        PH_TOKEN, PH_WDATA: begin
                            logic [4:0] bi;
                            logic [7:0] b;
                            bi = (phase_reg == PH_TOKEN) ? 5'd0 : idx_reg;
                            b = csd_v_reg[bi[3:0]] ? csd_reg[bi[3:0]] : 8'd0;
                            phase_next = PH_WDATA; do_x = 1'b1; x_sel = 1'b1;
                            if (bi < 5'd15) begin
                                crc_next = crc7_add(crc_reg, b);
                                idx_next = bi + 5'd1; x_tx = b;
                            end else begin
                                idx_next = bi; phase_next = PH_WCRC;
                                x_tx = {crc_reg, 1'b1};
                            end
                        end
                        PH_WCRC: begin
                            idx_next = 5'd0; phase_next = PH_DUMMY; do_x = 1'b1; x_sel = 1'b1;
                        end
                        PH_DUMMY: begin
                            idx_next = idx_reg + 5'd1; do_x = 1'b1; x_sel = 1'b1;
                            if (idx_reg + 5'd1 >= 5'd2) begin
                                poll_next = 16'd0; phase_next = PH_BUSY;
                            end
                        end
                        PH_BUSY: begin
                            poll_next = poll_inc;
                            if (rx != 8'd0) begin do_fin = 1'b1; fin_st = ST_OK; end
                            else if (poll_inc >= e_busy) begin
                                do_fin = 1'b1; fin_st = ST_TIMEOUT;
                            end else begin
                                do_x = 1'b1; x_sel = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Command completion, including the CMD55 leg of ACMD41.
            if (do_cc) begin
                if (acmd_reg) begin
                    acmd_next = 1'b0;
                    if (r > 8'd1) do_ret = 1'b1;
                    else begin do_issue = 1'b1; issue_wire = 8'h69; end
                end else do_ret = 1'b1;
            end

            if (do_ret) begin
                unique case (ret_reg)
                    R_CMD0: begin
                        try_next = try_inc;
                        if (r == 8'h01) begin
                            do_beg = 1'b1; beg_wire = 8'h48; beg_arg = 32'h1AA;
                            beg_ret = R_CMD8;
                        end else if (try_inc >= e_idle) begin
                            do_fin = 1'b1; fin_st = ST_NODET;
                        end else begin
                            do_beg = 1'b1; beg_wire = 8'h40; beg_ret = R_CMD0;
                        end
                    end
                    R_CMD8: begin
                        if (r == 8'h01) begin
                            idx_next = 5'd0; phase_next = PH_BURN; do_x = 1'b1; x_sel = 1'b1;
                        end else begin
                            do_beg = 1'b1; beg_wire = 8'h7A; beg_ret = R_CMD58;
                        end
                    end
                    R_ACMD41: begin
                        try_next = try_inc;
                        if (r == 8'd0 || try_inc >= e_init) begin
                            kind_next = 2'd2; phase_next = PH_FINAL; do_x = 1'b1;
                            x_sel = sel_reg;
                        end else begin
                            do_beg = 1'b1; beg_wire = 8'h69; beg_arg = 32'h4000_0000;
                            beg_acmd = 1'b1; beg_ret = R_ACMD41;
                        end
                    end
                    R_CMD58: begin
                        if (r == 8'h01) begin
                            idx_next = 5'd0; phase_next = PH_BURN; do_x = 1'b1; x_sel = 1'b1;
                        end else begin
                            phase_next = PH_FINAL; do_x = 1'b1; x_sel = sel_reg;
                        end
                    end
                    R_CMD1: begin
                        try_next = try_inc;
                        do_beg = 1'b1;
                        if (r == 8'd0 || try_inc >= e_init) begin
                            beg_wire = 8'h50; beg_arg = 32'd512; beg_ret = R_CMD16;
                        end else begin
                            beg_wire = 8'h41; beg_ret = R_CMD1;
                        end
                    end
                    R_CMD16: begin
                        kind_next = 2'd1; phase_next = PH_FINAL; do_x = 1'b1;
                        x_sel = sel_reg;
                    end
                    R_CMD9: begin
                        poll_next = 16'd0; phase_next = PH_DWAIT; do_x = 1'b1; x_sel = 1'b1;
                    end
                    default: begin
                        if (r != 8'd0) begin do_fin = 1'b1; fin_st = ST_RWFAIL; end
                        else begin
                            crc_next = 7'd0; phase_next = PH_TOKEN; do_x = 1'b1;
                            x_sel = 1'b1; x_tx = 8'hFE;
                        end
                    end
                endcase
            end

            if (do_beg) begin
                ret_next = beg_ret; arg_next = beg_arg; acmd_next = beg_acmd;
                do_issue = 1'b1; issue_wire = beg_acmd ? 8'h77 : beg_wire;
            end
            if (do_issue) begin
                cmd_next = issue_wire; phase_next = PH_C_PRE; do_x = 1'b1;
                x_sel = 1'b0; x_tx = 8'hFF;
            end
            if (do_x) begin
                emit = 1'b1; is_ex = 1'b1; o_tx = x_tx; o_sel = x_sel; sel_next = x_sel;
            end
            if (do_fin) begin
                emit = 1'b1; is_ex = 1'b0; o_tx = 8'd0; o_sel = 1'b0; o_st = fin_st;
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wake_reg <= 8'd10; idle_reg <= 8'd10; resp_reg <= 8'd10;
            init_reg <= 16'd20000; data_reg <= 8'd100; busyp_reg <= 16'd65535;
            csd_v_reg <= '0; phase_reg <= PH_IDLE; cmd_reg <= 8'd0; idx_reg <= 5'd0;
            poll_reg <= 16'd0; try_reg <= 16'd0; crc_reg <= 7'd0; kind_reg <= 2'd0;
            arg_reg <= 32'd0; acmd_reg <= 1'b0; sel_reg <= 1'b0; ret_reg <= R_CMD0;
            last_reg <= 8'd0; ov_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx)
                    CFG_WAKE: wake_reg  <= cfg_data[7:0];
                    CFG_IDLE: idle_reg  <= cfg_data[7:0];
                    CFG_RESP: resp_reg  <= cfg_data[7:0];
                    CFG_INIT: init_reg  <= cfg_data;
                    CFG_DATA: data_reg  <= cfg_data[7:0];
                    CFG_BUSY: busyp_reg <= cfg_data;
                    default: ;
                endcase
            end
            phase_reg <= phase_next; cmd_reg <= cmd_next; idx_reg <= idx_next;
            poll_reg <= poll_next; try_reg <= try_next; crc_reg <= crc_next;
            kind_reg <= kind_next; arg_reg <= arg_next; acmd_reg <= acmd_next;
            sel_reg <= sel_next; ret_reg <= ret_next; last_reg <= last_next;
            if (clr) csd_v_reg <= '0;
            else if (tog) begin
                csd_v_reg[14] <= 1'b1;
                csd_reg[14] <= (csd_v_reg[14] ? csd_reg[14] : 8'd0) ^ 8'h10;
            end else if (wr_en) begin
                csd_v_reg[wr_idx] <= 1'b1;
                csd_reg[wr_idx] <= wr_data;
            end
            if (emit) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
            if (emit) begin
                res_reg.tx_byte <= o_tx;
                res_reg.exchange <= is_ex;
                res_reg.select_card <= o_sel;
                res_reg.done_res <= !is_ex;
                res_reg.status <= o_st;
                res_reg.card_type <= kind_next;
                res_reg.locked <= tog ? !lock_bit : (clr ? 1'b0 :
                    ((wr_en && wr_idx == 4'd14) ? wr_data[4] : lock_bit));
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_res   = res_reg;
endmodule

// File: tb/tb_top.sv
// Self-checking testbench for sd_spi_csd_lock_sequencer_core.
// Depends on sdcl_pkg; drives the stream ports with a card model and checks against its own predictor.
`timescale 1ns / 1ps

module tb_top;
    import sdcl_pkg::*;

    localparam int LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [5:0] {
        P_IDLE, P_WAKE, P_PRE, P_SEL, P_CMD, P_ARG, P_CRC, P_RESP, P_TAIL, P_BURN,
        P_FINAL, P_DWAIT, P_DREAD, P_DCRC, P_TOKEN, P_WDATA, P_WCRC, P_DUMMY, P_BUSY
    } seq_phase_t;
    typedef enum logic [2:0] {
        R_CMD0, R_CMD8, R_ACMD41, R_CMD58, R_CMD1, R_CMD16, R_CMD9, R_CMD27
    } ret_t;

    localparam logic [7:0] W_CMD0 = 8'h40, W_CMD1 = 8'h41, W_CMD8 = 8'h48, W_CMD9 = 8'h49;
    localparam logic [7:0] W_CMD16 = 8'h50, W_CMD27 = 8'h5B, W_CMD41 = 8'h69;
    localparam logic [7:0] W_CMD55 = 8'h77, W_CMD58 = 8'h7A;
    localparam logic [2:0] REG_WAKE = 3'd0, REG_IDLE = 3'd1, REG_RESP = 3'd2;
    localparam logic [2:0] REG_INIT = 3'd3, REG_DATA = 3'd4, REG_BUSY = 3'd5;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // rx_byte[7:0]
    logic [1:0]  s_tuser = '0;   // func[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // tx_byte[7:0], exchange, select_card, done_res,
                                 // status[1:0], card_type[1:0], locked

    sd_spi_csd_lock_sequencer_core DUT (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    // predictor state
    logic [15:0] reg_val [6];
    logic [7:0]  csd [16];
    seq_phase_t  ph;
    logic [7:0]  cur_cmd, last_resp;
    logic [4:0]  bidx;
    logic [15:0] polls, tries;
    logic [6:0]  crc;
    logic [1:0]  kind;
    logic [31:0] arg;
    logic        acmd, cs;
    ret_t        ret;
    logic [7:0]  o_tx;
    logic        o_ex, o_sel, o_done, o_valid;
    logic [1:0]  o_stat;

    sdcl_result_t expected_results[$];
    int fails = 0;
    int cycles = 0;
    bit hold_req = 1'b0;
    int burst_left = 0;

    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 0) ? 16'd1 : v;
    endfunction

    function automatic logic [6:0] crc7_step(input logic [6:0] c_in, input logic [7:0] b);
        logic [7:0] c;
        logic [7:0] d;
        c = {1'b0, c_in};
        d = b;
        for (int k = 0; k < 8; k++) begin
            c = c << 1;
            if ((d[7] ^ c[7]) == 1'b1) c = c ^ 8'h09;
            d = d << 1;
        end
        return c[6:0];
    endfunction

    function automatic void xfer(input logic [7:0] tx, input logic sel);
        o_tx = tx; o_ex = 1; o_sel = sel; o_done = 0; o_stat = ST_OK; o_valid = 1; cs = sel;
    endfunction

    function automatic void finish_op(input logic [1:0] st);
        o_tx = 0; o_ex = 0; o_sel = 0; o_done = 1; o_stat = st; o_valid = 1; ph = P_IDLE;
    endfunction

    function automatic void issue(input logic [7:0] w);
        cur_cmd = w; ph = P_PRE; xfer(8'hFF, 0);
    endfunction

    function automatic void start_cmd(input logic [7:0] w, input logic [31:0] a,
                                      input logic ac, input ret_t r);
        ret = r; arg = a; acmd = ac;
        issue(ac ? W_CMD55 : w);
    endfunction

    function automatic void start_burn();
        bidx = 0; ph = P_BURN; xfer(8'hFF, 1);
    endfunction

    function automatic void final_byte();
        ph = P_FINAL; xfer(8'hFF, cs);
    endfunction

    function automatic void resume_after(input logic [7:0] r);
        case (ret)
            R_CMD0: begin
                tries++;
                if (r == 8'h01) start_cmd(W_CMD8, 32'h1AA, 0, R_CMD8);
                else if (tries >= at_least_one(reg_val[REG_IDLE])) finish_op(ST_NODET);
                else start_cmd(W_CMD0, 0, 0, R_CMD0);
            end
            R_CMD8: begin
                if (r == 8'h01) start_burn();
                else start_cmd(W_CMD58, 0, 0, R_CMD58);
            end
            R_ACMD41: begin
                tries++;
                if (r == 0 || tries >= at_least_one(reg_val[REG_INIT])) begin
                    kind = 2; final_byte();
                end else start_cmd(W_CMD41, 32'h4000_0000, 1, R_ACMD41);
            end
            R_CMD58: begin
                if (r == 8'h01) start_burn();
                else final_byte();
            end
            R_CMD1: begin
                tries++;
                if (r == 0 || tries >= at_least_one(reg_val[REG_INIT]))
                    start_cmd(W_CMD16, 32'd512, 0, R_CMD16);
                else start_cmd(W_CMD1, 0, 0, R_CMD1);
            end
            R_CMD16: begin
                kind = 1; final_byte();
            end
            R_CMD9: begin
                polls = 0; ph = P_DWAIT; xfer(8'hFF, 1);
            end
            default: begin
                if (r != 0) finish_op(ST_RWFAIL);
                else begin
                    crc = 0; ph = P_TOKEN; xfer(8'hFE, 1);
                end
            end
        endcase
    endfunction

    function automatic void cmd_done(input logic [7:0] r);
        if (acmd) begin
            acmd = 0;
            if (r > 1) resume_after(r);
            else issue(W_CMD41);
        end else resume_after(r);
    endfunction

    function automatic void write_data();
        logic [7:0] b;
        ph = P_WDATA;
        if (bidx < 15) begin
            b = csd[bidx[3:0]];
            crc = crc7_step(crc, b);
            bidx++;
            xfer(b, 1);
        end else begin
            ph = P_WCRC;
            xfer({crc, 1'b1}, 1);
        end
    endfunction

    function automatic void advance(input logic [7:0] rx);
        logic [31:0] a;
        a = acmd ? 32'd0 : arg;
        case (ph)
            P_WAKE: begin
                polls++;
                if (polls < at_least_one(reg_val[REG_WAKE])) xfer(8'hFF, 0);
                else begin
                    tries = 0; start_cmd(W_CMD0, 0, 0, R_CMD0);
                end
            end
            P_PRE: begin ph = P_SEL; xfer(8'hFF, 1); end
            P_SEL: begin ph = P_CMD; xfer(cur_cmd, 1); end
            P_CMD: begin bidx = 0; ph = P_ARG; xfer(a[31:24], 1); end
            P_ARG: begin
                bidx++;
                if (bidx < 4) xfer(8'(a >> (24 - 8 * bidx)), 1);
                else begin
                    ph = P_CRC;
                    xfer(cur_cmd == W_CMD0 ? 8'h95 : cur_cmd == W_CMD8 ? 8'h87 : 8'h01, 1);
                end
            end
            P_CRC: begin polls = 0; ph = P_RESP; xfer(8'hFF, 1); end
            P_RESP: begin
                polls++;
                if (!rx[7] || polls >= at_least_one(reg_val[REG_RESP])) begin
                    last_resp = rx;
                    if (cur_cmd inside {W_CMD8, W_CMD9, W_CMD27, W_CMD58}) cmd_done(rx);
                    else begin
                        ph = P_TAIL; xfer(8'hFF, 0);
                    end
                end else xfer(8'hFF, 1);
            end
            P_TAIL: cmd_done(last_resp);
            P_BURN: begin
                bidx++;
                if (bidx < 4) xfer(8'hFF, 1);
                else begin
                    tries = 0;
                    if (cur_cmd == W_CMD8) start_cmd(W_CMD41, 32'h4000_0000, 1, R_ACMD41);
                    else start_cmd(W_CMD1, 0, 0, R_CMD1);
                end
            end
            P_FINAL: begin
                for (int i = 0; i < 16; i++) csd[i] = 0;
                start_cmd(W_CMD9, 0, 0, R_CMD9);
            end
            P_DWAIT: begin
                polls++;
                if (rx == 8'hFE) begin
                    bidx = 0; ph = P_DREAD; xfer(8'hFF, 1);
                end else if (rx != 8'hFF || polls >= at_least_one(reg_val[REG_DATA]))
                    finish_op(ST_RWFAIL);
                else xfer(8'hFF, 1);
            end
            P_DREAD: begin
                if (bidx < 16) csd[bidx[3:0]] = rx;
                bidx++;
                if (bidx < 16) xfer(8'hFF, 1);
                else begin
                    ph = P_DCRC; xfer(8'hFF, 1);
                end
            end
            P_DCRC: finish_op(ST_OK);
            P_TOKEN: begin bidx = 0; write_data(); end
            P_WDATA: write_data();
            P_WCRC: begin bidx = 0; ph = P_DUMMY; xfer(8'hFF, 1); end
            P_DUMMY: begin
                bidx++;
                if (bidx < 2) xfer(8'hFF, 1);
                else begin
                    polls = 0; ph = P_BUSY; xfer(8'hFF, 1);
                end
            end
            P_BUSY: begin
                polls++;
                if (rx != 0) finish_op(ST_OK);
                else if (polls >= at_least_one(reg_val[REG_BUSY])) finish_op(ST_TIMEOUT);
                else xfer(8'hFF, 1);
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_sequencer(input logic [1:0] f, input logic [7:0] rx);
        sdcl_result_t r;
        o_valid = 0;
        if (f == FUNC_READ) begin
            kind = 0; acmd = 0; polls = 0; ph = P_WAKE; xfer(8'hFF, 0);
        end else if (f == FUNC_TOGGLE) begin
            csd[14] = csd[14] ^ 8'h10;
            start_cmd(W_CMD27, 0, 0, R_CMD27);
        end else if (f == FUNC_BYTE && ph != P_IDLE) begin
            advance(rx);
        end
        if (o_valid) begin
            r.tx_byte = o_tx; r.exchange = o_ex; r.select_card = o_sel;
            r.done_res = o_done; r.status = o_stat; r.card_type = kind;
            r.locked = csd[14][4];
            expected_results.push_back(r);
        end
    endfunction

    // card behavior: plausible answers in the phases that wait on the card
    function automatic logic [7:0] card_answer();
        int p;
        p = $urandom_range(0, 99);
        if (ph == P_RESP) begin
            if (p < 10) return 8'hFF;
            case (cur_cmd)
                W_CMD0:  return p < 85 ? 8'h01 : 8'($urandom);
                W_CMD8:  return p < 60 ? 8'h01 : 8'h05;
                W_CMD55: return p < 90 ? 8'h01 : 8'h05;
                W_CMD41, W_CMD1: return p < 50 ? 8'h00 : 8'h01;
                W_CMD58: return p < 80 ? 8'h01 : 8'h00;
                W_CMD27: return p < 85 ? 8'h00 : 8'h04;
                default: return p < 90 ? 8'h00 : 8'($urandom);
            endcase
        end
        if (ph == P_DWAIT) return p < 55 ? 8'hFE : p < 92 ? 8'hFF : 8'($urandom);
        if (ph == P_BUSY) return p < 50 ? 8'h00 : 8'($urandom);
        return 8'($urandom);
    endfunction

    task automatic send_item(input logic [1:0] f, input logic [7:0] rx);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= rx;
        do @(posedge aclk); while (!s_tready);
        predict_sequencer(f, rx);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        reg_val[idx] = (idx == REG_INIT || idx == REG_BUSY) ? val : {8'h00, val[7:0]};
    endtask

    task automatic set_regs(input logic [15:0] w, input logic [15:0] i, input logic [15:0] r,
                            input logic [15:0] n, input logic [15:0] d, input logic [15:0] b);
        wait_idle();
        write_reg(REG_WAKE, w); write_reg(REG_IDLE, i); write_reg(REG_RESP, r);
        write_reg(REG_INIT, n); write_reg(REG_DATA, d); write_reg(REG_BUSY, b);
    endtask

    // one full operation answered by the card model
    task automatic run_op(input logic [1:0] f);
        int guard;
        guard = 0;
        send_item(f, 8'($urandom));
        while (ph != P_IDLE && guard < 4000) begin
            send_item(FUNC_BYTE, card_answer());
            guard++;
        end
    endtask

    task automatic test_directed();
        send_item(FUNC_UNUSED, 8'hFF);    // unused func code
        send_item(FUNC_BYTE, 8'h00);      // byte while idle
        send_item(FUNC_BYTE, 8'hFF);
        set_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        run_op(FUNC_TOGGLE);              // toggle on the reset CSD
        run_op(FUNC_READ);
        set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(FUNC_READ, 8'h00);
        send_item(FUNC_BYTE, 8'h5A);
        send_item(FUNC_TOGGLE, 8'hA5);    // start while busy
        run_op(FUNC_READ);
    endtask

    task automatic test_extremes();
        set_regs(16'd255, 16'd255, 16'd255, 16'hFFFF, 16'd255, 16'hFFFF);
        run_op(FUNC_READ);
        run_op(FUNC_TOGGLE);
        set_regs(16'd10, 16'd10, 16'd10, 16'd20000, 16'd100, 16'd65535);
        run_op(FUNC_READ);
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_req = 1'b1;
        run_op(FUNC_TOGGLE);
        wait_idle();
    endtask

    task automatic test_random();
        int sent;
        int p;
        sent = 0;
        while (sent < 1400) begin
            if (sent % 300 == 0)
                set_regs($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 4),
                         $urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 6));
            p = $urandom_range(0, 99);
            if (p < 3) send_item(2'($urandom), 8'($urandom));
            else if (ph == P_IDLE) send_item(p < 70 ? FUNC_READ : FUNC_TOGGLE, 8'($urandom));
            else if (p < 4) send_item(p[0] ? FUNC_READ : FUNC_TOGGLE, 8'($urandom));
            else send_item(FUNC_BYTE, card_answer());
            sent++;
        end
    endtask

    // receiver: own stall pattern, with one long hold on request
    initial begin
        int mode;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                mode = (cycles / 500) % 3;
                m_tready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge aclk) begin
        sdcl_result_t got;
        sdcl_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got.tx_byte     = m_tdata[7:0];
            got.exchange    = m_tdata[8];
            got.select_card = m_tdata[9];
            got.done_res    = m_tdata[10];
            got.status      = m_tdata[12:11];
            got.card_type   = m_tdata[14:13];
            got.locked      = m_tdata[15];
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                fails++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got.tx_byte !== exp_r.tx_byte || got.exchange !== exp_r.exchange ||
                    got.select_card !== exp_r.select_card || got.done_res !== exp_r.done_res ||
                    got.status !== exp_r.status || got.card_type !== exp_r.card_type ||
                    got.locked !== exp_r.locked) begin
                    $display("%0t: mismatch expected tx=%h ex=%b sel=%b done=%b st=%0d ty=%0d lk=%b",
                             $time, exp_r.tx_byte, exp_r.exchange, exp_r.select_card,
                             exp_r.done_res, exp_r.status, exp_r.card_type, exp_r.locked);
                    $display("%0t:          actual   tx=%h ex=%b sel=%b done=%b st=%0d ty=%0d lk=%b",
                             $time, got.tx_byte, got.exchange, got.select_card,
                             got.done_res, got.status, got.card_type, got.locked);
                    fails++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        reg_val[REG_WAKE] = 10; reg_val[REG_IDLE] = 10; reg_val[REG_RESP] = 10;
        reg_val[REG_INIT] = 20000; reg_val[REG_DATA] = 100; reg_val[REG_BUSY] = 65535;
        for (int i = 0; i < 16; i++) csd[i] = 0;
        ph = P_IDLE; cur_cmd = 0; bidx = 0; polls = 0; tries = 0; crc = 0; kind = 0;
        arg = 0; acmd = 0; cs = 0; ret = R_CMD0; last_resp = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_extremes();
        test_backpressure();
        test_random();
        wait_idle();
        repeat (20) @(posedge aclk);
        if (fails == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
sv/sdcl_pkg.sv
sv/sdcl_front.sv
sv/sdcl_back.sv
sv/sd_spi_csd_lock_sequencer_core.sv
tb/tb_top.sv
